>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the supply voltage monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define TMSV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tmsv assertion failed");
// Checked on every clock edge, reset included.
`define TMSV_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tmsv assertion failed");
`else
`define TMSV_ASSERT(lbl, prop)
`define TMSV_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/tmsv_pkg.sv
// Constants of the trimmed-mean supply voltage monitor.
package tmsv_pkg;

    localparam int SAMPLES     = 20;
    localparam int SAMPLE_BITS = 12;
    localparam int SCALE_BITS  = 20;
    localparam int VOLT_BITS   = 8;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(50176);

    // block sum never exceeds SAMPLES full-scale conversions
    localparam int SUM_BITS   = $clog2(SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int COUNT_BITS = $clog2(SAMPLES);
    // the shared divider takes both the trimmed sum and the scale
    localparam int DIV_BITS   = (SUM_BITS > SCALE_BITS) ? SUM_BITS : SCALE_BITS;
    localparam int STEP_BITS  = $clog2(DIV_BITS);
    // remainder and divisor: the mean and SAMPLES-2 both fit a sample
    localparam int REM_BITS   = SAMPLE_BITS;

endpackage

>>> rtl/tmsv_if.sv
// Handshake channels of the supply voltage monitor: samples, results, scale writes.
interface tmsv_sample_if;
    logic                             valid;
    logic                             ready;
    logic [tmsv_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface tmsv_result_if;
    logic                           valid;
    logic                           ready;
    logic [tmsv_pkg::VOLT_BITS-1:0] voltage_tenths;
    logic                           saturated;
    logic                           zero_mean_error;

    modport source (output valid, output voltage_tenths, output saturated,
                    output zero_mean_error, input ready);
    modport sink   (input valid, input voltage_tenths, input saturated,
                    input zero_mean_error, output ready);
endinterface

interface tmsv_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tmsv_pkg::SCALE_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/trimmed_mean_supply_voltage_core.sv
// Trimmed-mean supply voltage monitor: block accumulator and bit-serial divider.
//
//  channel    dir  beat contents
//  i_sample   in   sample (12 bit conversion of the internal reference)
//  o_result   out  voltage_tenths, saturated, zero_mean_error
//  i_cfg      in   data: reference_scale (20 bit)
//
// Samples are taken one per cycle until a block of SAMPLES is complete.
// The last beat of a block starts the result: S_TRIM trims the sum, S_DIV1
// forms the mean, S_MEAN checks it, S_DIV2 divides scale by mean (skipped
// for a zero mean) and S_FIN saturates, both divisions on one shift divider.
// i_sample.ready is low during all of this and while a finished result waits
// behind a stalled o_result beat; scale writes are always taken.
// Reset clears the block and restores the reset scale.
`include "assert_macros.svh"

module trimmed_mean_supply_voltage_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tmsv_sample_if.sink    i_sample,
    tmsv_result_if.source  o_result,
    tmsv_cfg_if.sink       i_cfg
);
    import tmsv_pkg::*;

    typedef enum logic [2:0] {
        S_ACC,
        S_TRIM,
        S_DIV1,
        S_MEAN,
        S_DIV2,
        S_FIN
    } t_state;

    t_state                 r_state,  n_state;
    logic [SCALE_BITS-1:0]  r_scale,  n_scale;
    logic [SUM_BITS-1:0]    r_sum,    n_sum;
    logic [SAMPLE_BITS-1:0] r_min,    n_min;
    logic [SAMPLE_BITS-1:0] r_max,    n_max;
    logic [COUNT_BITS-1:0]  r_count,  n_count;
    logic [DIV_BITS-1:0]    r_quo,    n_quo;
    logic [REM_BITS-1:0]    r_rem,    n_rem;
    logic [REM_BITS-1:0]    r_div,    n_div;
    logic [STEP_BITS-1:0]   r_step,   n_step;
    logic                   r_zero,   n_zero;
    logic                   r_ovalid, n_ovalid;
    logic [VOLT_BITS-1:0]   r_volt,   n_volt;
    logic                   r_sat,    n_sat;
    logic                   r_zerr,   n_zerr;

    logic                   s_accept;
    logic [REM_BITS:0]      s_rem_sh;
    logic                   s_ge;
    logic [REM_BITS:0]      s_rem_sub;
    logic                   s_step_last;
    logic                   s_out_free;

    assign i_sample.ready = (r_state == S_ACC);
    assign i_cfg.ready    = 1'b1;
    assign s_accept       = i_sample.valid && (r_state == S_ACC);
    assign s_out_free     = !r_ovalid || o_result.ready;

    // one restoring division step per cycle
    assign s_rem_sh    = {r_rem, r_quo[DIV_BITS-1]};
    assign s_ge        = (s_rem_sh >= {1'b0, r_div});
    assign s_rem_sub   = s_rem_sh - {1'b0, r_div};
    assign s_step_last = (r_step == STEP_BITS'(DIV_BITS - 1));

    always_comb begin
        n_state  = r_state;
        n_scale  = r_scale;
        n_sum    = r_sum;
        n_min    = r_min;
        n_max    = r_max;
        n_count  = r_count;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_step   = r_step;
        n_zero   = r_zero;
        n_ovalid = r_ovalid;
        n_volt   = r_volt;
        n_sat    = r_sat;
        n_zerr   = r_zerr;

        if (i_cfg.valid) begin
            n_scale = i_cfg.data;
        end
        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_ACC: begin
                if (s_accept) begin
                    n_sum = r_sum + SUM_BITS'(i_sample.sample);
                    if (i_sample.sample < r_min) begin
                        n_min = i_sample.sample;
                    end
                    if (i_sample.sample > r_max) begin
                        n_max = i_sample.sample;
                    end
                    if (r_count == COUNT_BITS'(SAMPLES - 1)) begin
                        n_count = '0;
                        n_state = S_TRIM;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_TRIM: begin
                n_quo   = DIV_BITS'(r_sum - SUM_BITS'(r_min) - SUM_BITS'(r_max));
                n_div   = REM_BITS'(SAMPLES - 2);
                n_rem   = '0;
                n_step  = '0;
                n_sum   = '0;
                n_min   = '1;
                n_max   = '0;
                n_state = S_DIV1;
            end
            S_DIV1, S_DIV2: begin
                n_quo  = {r_quo[DIV_BITS-2:0], s_ge};
                n_rem  = s_ge ? s_rem_sub[REM_BITS-1:0] : s_rem_sh[REM_BITS-1:0];
                n_step = r_step + 1'b1;
                if (s_step_last) begin
                    n_state = (r_state == S_DIV1) ? S_MEAN : S_FIN;
                end
            end
            S_MEAN: begin
                n_zero = (r_quo == '0);
                n_div  = r_quo[REM_BITS-1:0];
                n_quo  = DIV_BITS'(r_scale);
                n_rem  = '0;
                n_step = '0;
                n_state = (r_quo == '0) ? S_FIN : S_DIV2;
            end
            S_FIN: begin
                if (s_out_free) begin
                    n_ovalid = 1'b1;
                    n_zerr   = r_zero;
                    if (r_zero) begin
                        n_volt = '1;
                        n_sat  = 1'b0;
                    end else if (r_quo[DIV_BITS-1:VOLT_BITS] != '0) begin
                        n_volt = '1;
                        n_sat  = 1'b1;
                    end else begin
                        n_volt = r_quo[VOLT_BITS-1:0];
                        n_sat  = 1'b0;
                    end
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_scale  <= SCALE_RESET;
            r_sum    <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_count  <= '0;
            r_step   <= '0;
            r_zero   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scale  <= n_scale;
            r_sum    <= n_sum;
            r_min    <= n_min;
            r_max    <= n_max;
            r_count  <= n_count;
            r_step   <= n_step;
            r_zero   <= n_zero;
            r_ovalid <= n_ovalid;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_volt <= n_volt;
        r_sat  <= n_sat;
        r_zerr <= n_zerr;
    end

    assign o_result.valid           = r_ovalid;
    assign o_result.voltage_tenths  = r_volt;
    assign o_result.saturated       = r_sat;
    assign o_result.zero_mean_error = r_zerr;

    `TMSV_ASSERT(a_result_from_fin, $rose(r_ovalid) |-> $past(r_state == S_FIN))
    `TMSV_ASSERT(a_zero_clamps, r_ovalid && r_zerr |-> (r_volt == '1) && !r_sat)
    `TMSV_ASSERT(a_sat_clamps, r_ovalid && r_sat |-> (r_volt == '1) && !r_zerr)
    `TMSV_ASSERT(a_min_le_max, (r_state == S_ACC) && (r_count != '0) |-> r_min <= r_max)
    `TMSV_ASSERT(a_idle_count, (r_state != S_ACC) |-> (r_count == '0))

endmodule
